@@ sv/maze_backtracker_step_assert.svh @@
// Assertion macros for the maze backtracker step block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MAZE_BACKTRACKER_STEP_ASSERT_SVH
`define MAZE_BACKTRACKER_STEP_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define MBS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A cause that must be followed by an effect at the next clock edge.
`define MBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A cause that must come with an effect at the same clock edge.
`define MBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define MBS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define MBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define MBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/mbs_pkg.sv @@
// Shared types and constants of the maze backtracker step block.
// Used by the controller, the datapath and the top level; no dependencies.
package mbs_pkg;

    localparam int DEF_ROWS = 16;
    localparam int DEF_COLS = 16;

    // Stream payload widths.
    localparam int RND_W      = 16;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int POS_W      = 4;
    localparam int DIR_W      = 2;
    localparam int CNT_OUT_W  = 9;
    localparam int OUT_USER_W = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - (4 * POS_W + DIR_W + CNT_OUT_W);

    // Action code carried in the input tuser.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_STARTED   = 2'd0,
        KIND_CARVED    = 2'd1,
        KIND_BACKTRACK = 2'd2,
        KIND_FINISHED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    // Which row of the visited map is read this cycle.
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_UP   = 2'd1,
        RD_MID  = 2'd2,
        RD_DN   = 2'd3
    } t_rd;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic clr_seed;
        t_rd  rd;
        logic do_start;
        logic do_finish;
        logic do_decide;
        logic do_pop;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic is_full;
        logic need_pop;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

@@ sv/mbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the visited map and the backtrack stack.
module mbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mbs_ctrl.sv @@
// Sequencer of the maze backtracker step block.
// Depends on mbs_pkg; drives the datapath through t_cmd and reads t_stat.
module mbs_ctrl
    import mbs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_CHECK,
        S_RD_MID,
        S_RD_DN,
        S_DECIDE,
        S_POP,
        S_START_CLR,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd = RD_NONE;
        case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_start) begin
                    n_state = S_START_CLR;
                end else if (i_stat.is_full) begin
                    o_cmd.do_finish = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.rd = RD_UP;
                    n_state  = S_RD_MID;
                end
            end
            S_RD_MID: begin
                o_cmd.rd = RD_MID;
                n_state  = S_RD_DN;
            end
            S_RD_DN: begin
                o_cmd.rd = RD_DN;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.do_decide = 1'b1;
                n_state = i_stat.need_pop ? S_POP : S_EMIT;
            end
            S_POP: begin
                o_cmd.do_pop = 1'b1;
                n_state      = S_EMIT;
            end
            S_START_CLR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_seed = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.do_start = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ sv/mbs_dpath.sv @@
// Datapath of the maze backtracker step block: position, counters, visited
// map and backtrack stack RAMs, neighbor selection and the output register.
// Depends on mbs_pkg, mbs_ram and the assertion macro header.
`include "maze_backtracker_step_assert.svh"

module mbs_dpath
    import mbs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_in_action,
    input  logic [RND_W-1:0]      i_in_rnd,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_USER_W-1:0] o_out_kind,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CELLS = ROWS * COLS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int SA_W  = $clog2(CELLS);
    localparam int SE_W  = RW + CW;

    // Remainder of a value by three: base-four digits sum to the same
    // remainder, then one short fold and a compare settle it.
    function automatic logic [1:0] f_mod3(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_from_row;
    logic [CW-1:0]    r_from_col;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_depth;
    logic [RW-1:0]    r_clr_cnt;
    t_rd              r_rd_tag;
    logic             r_action;
    logic [RND_W-1:0] r_rnd;
    t_kind            r_kind;
    t_dir             r_dir;
    logic [COLS-1:0]  r_up;
    logic [COLS-1:0]  r_mid;
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [RW-1:0]    row_m1, row_p1;
    logic [CW-1:0]    col_m1, col_p1;
    logic             row_first, row_last, col_first, col_last;
    logic [COLS-1:0]  dn_word;
    logic [3:0]       ok;
    logic [2:0]       n_cand;
    logic [1:0]       pick_k;
    logic [2:0]       idx;
    logic             found;
    t_dir             sel_dir;
    logic [RW-1:0]    tgt_row;
    logic [CW-1:0]    tgt_col;
    logic [COLS-1:0]  base_word;
    logic [COLS-1:0]  bit_word;
    logic             carve;
    logic [CNT_W-1:0] depth_m1;

    logic             map_we;
    logic [RW-1:0]    map_waddr;
    logic [COLS-1:0]  map_wdata;
    logic [RW-1:0]    map_raddr;
    logic [COLS-1:0]  map_rdata;

    logic             stk_we;
    logic [SE_W-1:0]  stk_rdata;

    assign row_m1    = r_row - RW'(1);
    assign row_p1    = r_row + RW'(1);
    assign col_m1    = r_col - CW'(1);
    assign col_p1    = r_col + CW'(1);
    assign row_first = (r_row == '0);
    assign row_last  = (r_row == RW'(ROWS - 1));
    assign col_first = (r_col == '0);
    assign col_last  = (r_col == CW'(COLS - 1));
    assign depth_m1  = r_depth - CNT_W'(1);

    // The lower row arrives straight from the map RAM in the decide cycle.
    assign dn_word = map_rdata;

    always_comb begin
        ok[0] = row_first ? 1'b0 : !r_up[r_col];
        ok[1] = row_last  ? 1'b0 : !dn_word[r_col];
        ok[2] = col_first ? 1'b0 : !r_mid[col_m1];
        ok[3] = col_last  ? 1'b0 : !r_mid[col_p1];
    end

    assign n_cand = 3'($countones(ok));

    always_comb begin
        case (n_cand)
            3'd2:    pick_k = {1'b0, r_rnd[0]};
            3'd3:    pick_k = f_mod3(r_rnd);
            3'd4:    pick_k = r_rnd[1:0];
            default: pick_k = 2'd0;
        endcase
    end

    // Walk the candidates in up, down, left, right order to the chosen one.
    always_comb begin
        idx     = '0;
        found   = 1'b0;
        sel_dir = DIR_UP;
        for (int d = 0; d < 4; d++) begin
            if (ok[d]) begin
                if (!found && idx == {1'b0, pick_k}) begin
                    sel_dir = t_dir'(d[1:0]);
                    found   = 1'b1;
                end
                idx = idx + 3'd1;
            end
        end
    end

    always_comb begin
        tgt_row   = r_row;
        tgt_col   = r_col;
        base_word = r_mid;
        case (sel_dir)
            DIR_UP: begin
                tgt_row   = row_m1;
                base_word = r_up;
            end
            DIR_DOWN: begin
                tgt_row   = row_p1;
                base_word = dn_word;
            end
            DIR_LEFT:  tgt_col = col_m1;
            DIR_RIGHT: tgt_col = col_p1;
            default:   tgt_col = r_col;
        endcase
    end

    assign bit_word = {{(COLS - 1){1'b0}}, 1'b1} << tgt_col;
    assign carve    = i_cmd.do_decide && (ok != 4'd0);

    always_comb begin
        case (i_cmd.rd)
            RD_UP:   map_raddr = row_first ? r_row : row_m1;
            RD_DN:   map_raddr = row_last ? r_row : row_p1;
            default: map_raddr = r_row;
        endcase
    end

    always_comb begin
        if (i_cmd.clr_step) begin
            map_we    = 1'b1;
            map_waddr = r_clr_cnt;
            map_wdata = (i_cmd.clr_seed && r_clr_cnt == '0) ? COLS'(1) : '0;
        end else begin
            map_we    = carve;
            map_waddr = tgt_row;
            map_wdata = base_word | bit_word;
        end
    end

    assign stk_we = carve && (r_depth < CNT_W'(CELLS));

    mbs_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    mbs_ram #(
        .WIDTH (SE_W),
        .DEPTH (CELLS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[SA_W-1:0]),
        .i_wdata ({r_row, r_col}),
        .i_raddr (depth_m1[SA_W-1:0]),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_count     <= '0;
            r_depth     <= '0;
            r_clr_cnt   <= '0;
            r_rd_tag    <= RD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_tag <= i_cmd.rd;
            if (i_cmd.clr_step) begin
                r_clr_cnt <= o_stat.clr_last ? '0 : r_clr_cnt + RW'(1);
            end
            if (i_cmd.do_start) begin
                r_row   <= '0;
                r_col   <= '0;
                r_count <= CNT_W'(1);
                r_depth <= '0;
            end
            if (carve) begin
                r_row   <= tgt_row;
                r_col   <= tgt_col;
                r_count <= r_count + CNT_W'(1);
                if (stk_we) begin
                    r_depth <= r_depth + CNT_W'(1);
                end
            end else if (i_cmd.do_decide && r_depth != '0) begin
                r_depth <= depth_m1;
            end
            if (i_cmd.do_pop) begin
                {r_row, r_col} <= stk_rdata;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_in_action;
            r_rnd      <= i_in_rnd;
            r_from_row <= r_row;
            r_from_col <= r_col;
        end
        if (r_rd_tag == RD_UP) begin
            r_up <= map_rdata;
        end
        if (r_rd_tag == RD_MID) begin
            r_mid <= map_rdata;
        end
        if (i_cmd.do_start) begin
            r_from_row <= '0;
            r_from_col <= '0;
            r_kind     <= KIND_STARTED;
            r_dir      <= DIR_UP;
        end
        if (i_cmd.do_finish) begin
            r_kind <= KIND_FINISHED;
            r_dir  <= DIR_UP;
        end
        if (i_cmd.do_decide) begin
            r_kind <= carve ? KIND_CARVED : KIND_BACKTRACK;
            r_dir  <= carve ? sel_dir : DIR_UP;
        end
        if (i_cmd.load_out) begin
            r_out_kind <= r_kind;
            r_out_data <= {OUT_PAD_W'(0),
                           CNT_OUT_W'(r_count),
                           r_dir,
                           POS_W'(r_col),
                           POS_W'(r_row),
                           POS_W'(r_from_col),
                           POS_W'(r_from_row)};
        end
    end

    always_comb begin
        o_stat.is_start = (r_action == ACT_START);
        o_stat.is_full  = (r_count >= CNT_W'(CELLS));
        o_stat.need_pop = (ok == 4'd0) && (r_depth != '0);
        o_stat.clr_last = (r_clr_cnt == RW'(ROWS - 1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;

    `MBS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CELLS), "visited count beyond grid size")
    `MBS_ASSERT_ALWAYS(a_depth_le_count, i_clk, i_rst_n, r_depth <= r_count, "stack deeper than visited count")
    `MBS_ASSERT_NEXT(a_carve_counts, i_clk, i_rst_n, carve, r_count == $past(r_count) + CNT_W'(1), "carve did not bump count")
    `MBS_ASSERT_ALWAYS(a_map_one_writer, i_clk, i_rst_n, !(i_cmd.clr_step && carve), "clear sweep and carve collide")

endmodule

@@ sv/maze_backtracker_step.sv @@
// Randomized depth-first maze carving over a ROWS by COLS grid, one carving
// iteration per input item and exactly one result item per input item. The
// input tuser selects the action (start a new maze or take one step) and
// tdata carries a 16-bit random value that picks among the unvisited
// neighbors of the current cell, in up, down, left, right order, as
// random mod count. Each result reports what happened (started, carved,
// backtracked or finished), the cell before and after the item, the carved
// wall and the number of visited cells. Timing: after reset the block runs a
// clearing pass over the visited map, one map row per cycle, so it takes no
// item until the pass is done. An accepted step reads the map and decides;
// a backtrack that pops the stack adds a pop state, a dead end with an empty
// stack does not, a finished report skips the reads and a start reruns the
// clearing pass. The step time is set by the visited map, which is stored
// one grid row per word in a RAM with one read port and registered read
// data: the rows above, at and below the current cell are read in turn, and
// a pop adds one registered read of the stack RAM. Any result may wait in
// the output register while the next item is already taken.
// Depends on mbs_pkg, mbs_ctrl, mbs_dpath and mbs_ram.
module maze_backtracker_step
    import mbs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] random_value
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] action: 0 start, 1 step
    // Result items.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] from_row, [7:4] from_col, [11:8] to_row, [15:12] to_col,
    // [17:16] direction, [26:18] cells_visited, [31:27] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser    // [1:0] kind
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each item; it only raises ready when idle.
    mbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the maze state and the output register.
    mbs_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_action (s_axis_tuser[0]),
        .i_in_rnd    (s_axis_tdata[RND_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule

@@ verif/mbs_carve_checker.sv @@
// Checker for the maze backtracker step block: watches both item streams,
// predicts every result item from the accepted input items and compares.
// Depends on mbs_pkg for the stream widths and the kind and direction codes.
`timescale 1ns / 100ps

module mbs_carve_checker
    import mbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [OUT_USER_W-1:0] i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int GRID_ROWS  = DEF_ROWS;
    localparam int GRID_COLS  = DEF_COLS;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    typedef struct packed {
        t_kind                kind;
        logic [POS_W-1:0]     from_row;
        logic [POS_W-1:0]     from_col;
        logic [POS_W-1:0]     to_row;
        logic [POS_W-1:0]     to_col;
        t_dir                 direction;
        logic [CNT_OUT_W-1:0] cells_visited;
    } t_move;

    // Shadow copy of the carving state.
    logic seen_cell [GRID_CELLS];
    int   trail [GRID_CELLS];
    int   trail_depth;
    int   here_row;
    int   here_col;
    int   seen_count;

    t_move due_moves [$];
    int    fail_cnt;
    int    due_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = due_cnt;

    function automatic t_move carve_step(input logic act, input logic [RND_W-1:0] rnd);
        t_move mv;
        int    fr;
        int    fc;
        int    n;
        int    k;
        int    slot;
        int    cand_r [4];
        int    cand_c [4];
        t_dir  cand_d [4];
        fr = here_row;
        fc = here_col;
        n  = 0;
        mv = '0;
        mv.from_row = fr[POS_W-1:0];
        mv.from_col = fc[POS_W-1:0];
        if (act == ACT_START) begin
            foreach (seen_cell[i]) seen_cell[i] = 1'b0;
            seen_cell[0] = 1'b1;
            trail_depth  = 0;
            here_row     = 0;
            here_col     = 0;
            seen_count   = 1;
            mv.kind      = KIND_STARTED;
            mv.from_row  = '0;
            mv.from_col  = '0;
            mv.direction = DIR_UP;
        end else if (seen_count >= GRID_CELLS) begin
            // A finished maze leaves everything as it is.
            mv.kind      = KIND_FINISHED;
            mv.direction = DIR_UP;
        end else begin
            if (fr > 0 && !seen_cell[(fr - 1) * GRID_COLS + fc]) begin
                cand_r[n] = fr - 1; cand_c[n] = fc; cand_d[n] = DIR_UP; n++;
            end
            if (fr + 1 < GRID_ROWS && !seen_cell[(fr + 1) * GRID_COLS + fc]) begin
                cand_r[n] = fr + 1; cand_c[n] = fc; cand_d[n] = DIR_DOWN; n++;
            end
            if (fc > 0 && !seen_cell[fr * GRID_COLS + fc - 1]) begin
                cand_r[n] = fr; cand_c[n] = fc - 1; cand_d[n] = DIR_LEFT; n++;
            end
            if (fc + 1 < GRID_COLS && !seen_cell[fr * GRID_COLS + fc + 1]) begin
                cand_r[n] = fr; cand_c[n] = fc + 1; cand_d[n] = DIR_RIGHT; n++;
            end
            if (n > 0) begin
                k = int'(rnd) % n;
                // A push into a full stack is dropped.
                if (trail_depth < GRID_CELLS) begin
                    trail[trail_depth] = fr * GRID_COLS + fc;
                    trail_depth++;
                end
                here_row = cand_r[k];
                here_col = cand_c[k];
                seen_cell[here_row * GRID_COLS + here_col] = 1'b1;
                seen_count++;
                mv.kind      = KIND_CARVED;
                mv.direction = cand_d[k];
            end else begin
                // A dead end with an empty stack stays where it is.
                if (trail_depth > 0) begin
                    trail_depth--;
                    slot     = trail[trail_depth] % GRID_CELLS;
                    here_row = slot / GRID_COLS;
                    here_col = slot % GRID_COLS;
                end
                mv.kind      = KIND_BACKTRACK;
                mv.direction = DIR_UP;
            end
        end
        mv.to_row        = here_row[POS_W-1:0];
        mv.to_col        = here_col[POS_W-1:0];
        mv.cells_visited = seen_count[CNT_OUT_W-1:0];
        return mv;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    initial begin
        fail_cnt = 0;
        due_cnt  = 0;
    end

    always @(posedge i_clk) begin
        t_move want;
        if (!i_rst_n) begin
            foreach (seen_cell[i]) seen_cell[i] = 1'b0;
            trail_depth = 0;
            here_row    = 0;
            here_col    = 0;
            seen_count  = 0;
            due_moves.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (due_moves.size() == 0) begin
                    $error("result item with no expected item: tuser %0d tdata %h",
                           i_m_tuser, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want = due_moves.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("from_row", want.from_row, i_m_tdata[3:0]);
                    check_field("from_col", want.from_col, i_m_tdata[7:4]);
                    check_field("to_row", want.to_row, i_m_tdata[11:8]);
                    check_field("to_col", want.to_col, i_m_tdata[15:12]);
                    check_field("direction", want.direction, i_m_tdata[17:16]);
                    check_field("cells_visited", want.cells_visited, i_m_tdata[26:18]);
                    check_field("padding", 0, i_m_tdata[31:27]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_moves.insert(due_moves.size(), carve_step(i_s_tuser[0], i_s_tdata));
            end
        end
        due_cnt = due_moves.size();
    end

endmodule

@@ verif/tb_maze_backtracker_step.sv @@
// Testbench top for the maze backtracker step block: drives input items,
// throttles the result stream and prints the verdict.
// Depends on mbs_pkg, maze_backtracker_step and mbs_carve_checker.
`timescale 1ns / 100ps

module tb_maze_backtracker_step;
    import mbs_pkg::*;

    // This tail covers any item still in flight, a start with its clearing pass included.
    localparam int TAIL_CYCLES = 4 * DEF_ROWS + 16;
    // The limit sits well above the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tready = 1'b0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    wire  [OUT_USER_W-1:0] m_axis_tuser;

    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    // While set, neither side idles.
    logic calm = 1'b0;

    // Directed items: bit 16 is the action, bits 15:0 the random value.
    localparam logic [16:0] DIRECTED [22] = '{
        // Steps on the reset state, before any start has been seen.
        {ACT_STEP, 16'h0000}, {ACT_STEP, 16'hFFFF}, {ACT_STEP, 16'h8000},
        {ACT_STEP, 16'h0001},
        // A start ignores its random value.
        {ACT_START, 16'hFFFF},
        {ACT_STEP, 16'h0000}, {ACT_STEP, 16'hFFFF}, {ACT_STEP, 16'h5555},
        {ACT_STEP, 16'hAAAA}, {ACT_STEP, 16'h0001}, {ACT_STEP, 16'h0002},
        {ACT_STEP, 16'h0003},
        // Restart in the middle of a maze, then twice in a row.
        {ACT_START, 16'h0000}, {ACT_START, 16'h1234},
        {ACT_STEP, 16'h0000}, {ACT_STEP, 16'h0000}, {ACT_STEP, 16'h0000},
        {ACT_STEP, 16'h0000}, {ACT_STEP, 16'hFFFF}, {ACT_STEP, 16'hFFFF},
        {ACT_STEP, 16'h7FFF}, {ACT_STEP, 16'h000B}
    };

    maze_backtracker_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mbs_carve_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at random, one decision per falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("maze_backtracker_step test failed");
            $finish;
        end
    end

    // Offers one item, starting at a falling edge and returning at the falling
    // edge after it was taken. Valid drops only when an idle cycle is drawn,
    // so back-to-back items keep it high without a glitch.
    task automatic offer_item(input logic act, input logic [RND_W-1:0] rnd);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= rnd;
        s_axis_tuser[0] <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Random values are mostly full range, sometimes tiny so that low
    // remainders and exact multiples show up often.
    function automatic logic [RND_W-1:0] pick_rnd();
        if ($urandom_range(0, 3) == 0) begin
            return RND_W'($urandom_range(0, 7));
        end
        return RND_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            offer_item(DIRECTED[i][16], DIRECTED[i][15:0]);
        end

        // A complete maze needs at most 510 steps after its start; the extra
        // steps land on the finished report.
        offer_item(ACT_START, pick_rnd());
        repeat (540) offer_item(ACT_STEP, pick_rnd());

        // Hold the sender off until every result is back.
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // A second complete maze with no idling on either side.
        calm <= 1'b1;
        @(negedge i_clk);
        offer_item(ACT_START, pick_rnd());
        repeat (530) offer_item(ACT_STEP, pick_rnd());
        calm <= 1'b0;
        @(negedge i_clk);

        // Broken runs: restarts at random points of partial mazes.
        repeat (150) begin
            offer_item(($urandom_range(0, 11) == 0) ? ACT_START : ACT_STEP, pick_rnd());
        end
        // Noise: starts and steps in equal measure.
        repeat (50) begin
            offer_item($urandom_range(0, 1) ? ACT_STEP : ACT_START, pick_rnd());
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("maze_backtracker_step test passed");
        end else begin
            $display("maze_backtracker_step test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/mbs_pkg.sv
sv/mbs_ram.sv
sv/mbs_ctrl.sv
sv/mbs_dpath.sv
sv/maze_backtracker_step.sv
verif/mbs_carve_checker.sv
verif/tb_maze_backtracker_step.sv
